// File: design/assert_macros.svh
// Assertion macros shared by the affine transform stack RTL.
// Depends on clk_i and rst_ni being visible in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AFS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define AFS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define AFS_ASSERT_IMPL(name, ante, cons, msg)
`define AFS_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

// File: design/afs_pkg.sv
// Package for the affine transform stack: field widths, mode and status codes,
// sequencer state type. No dependencies.
`timescale 1ns / 1ps
package afs_pkg;
  localparam int WORD_W    = 32;
  localparam int MAT_WORDS = 6;
  localparam int ROW_WORDS = 3;
  localparam int CUR_AW    = 3;
  localparam int LIMIT_W   = 5;
  localparam int DEPTH_W   = 5;
  localparam int MODE_W    = 3;
  localparam int STAT_W    = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  localparam logic [MODE_W-1:0] MODE_XFORM = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MUL   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PUSH  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVF   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // positions of the diagonal coefficients in the current matrix
  localparam logic [CUR_AW-1:0] IDX_A0 = 3'd0;
  localparam logic [CUR_AW-1:0] IDX_B1 = 3'd4;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CALC,
    ST_PUSH,
    ST_POP
  } state_e;
endpackage

// File: design/afs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module afs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// File: design/afs_fxmul.sv
// Registered signed fixed-point multiplier: full product, arithmetic shift by
// the fraction width, low word kept. No dependencies.
`timescale 1ns / 1ps
module afs_fxmul #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic        [31:0] p_o
);
  logic signed [63:0] prod;
  logic        [31:0] p_q;

  assign prod = a_i * b_i;

  always_ff @(posedge clk_i) begin
    p_q <= prod[FRAC_BITS +: 32];
  end

  assign p_o = p_q;
endmodule

// File: design/affine_transform_stack_top.sv
// Top level of the affine transform stack: sequencer, current-matrix RAM,
// matrix stack RAM and the shared multiplier. Uses afs_pkg, afs_ram, afs_fxmul.
//
// Usage: a command word is taken when start_i is high and busy_o is low; its
// mode_i selects transform point, multiply current matrix, push, pop or clear.
// Exactly one result word follows, on result_x_o, result_y_o, status_o and
// depth_now_o, valid for the single cycle in which done_o is high. The
// receiver cannot stall; done_o rises in the cycle after the last step and a
// new command may be issued in that same cycle.
// Clear, a failed push or pop and unused modes finish from the idle state.
// One command is in flight at a time. Transform and multiply are paced by
// the single registered multiplier (two products per output coefficient)
// and by the one read port of the current-matrix RAM (a row is fetched
// before use). Push and pop move six words, one per cycle through the RAM
// ports. stack_limit_i is written when stack_limit_we_i is high; the user
// must write it only while idle, as the block does not enforce it. Reset:
// current matrix becomes identity (flagged, no RAM sweep), stack empty,
// limit 16. The stack RAM needs no clearing.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module affine_transform_stack_top #(
  parameter int STACK_DEPTH = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic                                 stack_limit_we_i,
  input  logic        [afs_pkg::LIMIT_W-1:0]   stack_limit_i,
  input  logic        [afs_pkg::MODE_W-1:0]    mode_i,
  input  logic signed [afs_pkg::WORD_W-1:0]    coef_a0_i,
  input  logic signed [afs_pkg::WORD_W-1:0]    coef_a1_i,
  input  logic signed [afs_pkg::WORD_W-1:0]    coef_a2_i,
  input  logic signed [afs_pkg::WORD_W-1:0]    coef_b0_i,
  input  logic signed [afs_pkg::WORD_W-1:0]    coef_b1_i,
  input  logic signed [afs_pkg::WORD_W-1:0]    coef_b2_i,
  input  logic signed [afs_pkg::WORD_W-1:0]    point_x_i,
  input  logic signed [afs_pkg::WORD_W-1:0]    point_y_i,
  output logic                                 done_o,
  output logic signed [afs_pkg::WORD_W-1:0]    result_x_o,
  output logic signed [afs_pkg::WORD_W-1:0]    result_y_o,
  output logic        [afs_pkg::STAT_W-1:0]    status_o,
  output logic        [afs_pkg::DEPTH_W-1:0]   depth_now_o
);
  import afs_pkg::*;

  localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int STK_WORDS = STACK_DEPTH * MAT_WORDS;
  localparam int SA_W      = $clog2(STK_WORDS);
  localparam int K_W       = 3;
  localparam word_t ONE    = word_t'(1) << FRAC_BITS;

  localparam logic [1:0] PH_A     = 2'd0;
  localparam logic [1:0] PH_B     = 2'd1;
  localparam logic [1:0] PH_SUM   = 2'd2;
  localparam logic [1:0] LAST_COL = 2'(ROW_WORDS - 1);

  state_e             state_q, state_d;
  logic [K_W-1:0]     k_q, k_d;
  logic               row_q, row_d;
  logic [1:0]         col_q, col_d;
  logic [1:0]         ph_q, ph_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               ident_q, ident_d;
  logic [LIMIT_W-1:0] stack_limit_q;
  logic               done_q, done_d;

  logic               xform_q;
  word_t              opu_q [ROW_WORDS];
  word_t              opv_q [ROW_WORDS];
  word_t              px_q, py_q;
  word_t              c_q [ROW_WORDS];
  word_t              acc_q;
  logic [SA_W-1:0]    base_q, base_d;
  logic [CUR_AW-1:0]  cur_rd_idx_q;
  word_t              rx_q, rx_d, ry_q, ry_d;
  logic [STAT_W-1:0]  status_q, status_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;

  logic               accept, full, finish, add_c2;
  logic [CNT_W-1:0]   idx_src;
  logic [CUR_AW-1:0]  row_base;
  logic [1:0]         last_col;
  word_t              cur_data, cur_rdata, stk_rdata, prod, sum, mul_u, mul_v;
  word_t              mul_a, mul_b;

  logic               cur_we, stk_we;
  logic [CUR_AW-1:0]  cur_waddr, cur_raddr;
  word_t              cur_wdata;
  logic [SA_W-1:0]    stk_waddr, stk_raddr;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);
  assign full   = (int'(cnt_q) >= int'(stack_limit_q)) || (int'(cnt_q) >= STACK_DEPTH);

  assign idx_src = (mode_i == MODE_POP) ? cnt_q - 1'b1 : cnt_q;
  assign base_d  = SA_W'(int'(idx_src) * MAT_WORDS);

  // identity flag stands in for the RAM contents after reset or clear
  assign cur_data = ident_q ?
                    (((cur_rd_idx_q == IDX_A0) || (cur_rd_idx_q == IDX_B1)) ? ONE : '0) :
                    cur_rdata;

  assign row_base = row_q ? CUR_AW'(ROW_WORDS) : '0;
  assign last_col = xform_q ? '0 : LAST_COL;
  assign add_c2   = xform_q || (col_q == LAST_COL);

  assign mul_u = xform_q ? px_q : opu_q[col_q];
  assign mul_v = xform_q ? py_q : opv_q[col_q];
  assign mul_a = (ph_q == PH_A) ? c_q[0] : c_q[1];
  assign mul_b = (ph_q == PH_A) ? mul_u : mul_v;
  assign sum   = acc_q + prod + (add_c2 ? c_q[2] : '0);

  afs_fxmul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (prod)
  );

  afs_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAT_WORDS)
  ) u_cur_ram (
    .clk_i  (clk_i),
    .we_i   (cur_we),
    .waddr_i(cur_waddr),
    .wdata_i(cur_wdata),
    .raddr_i(cur_raddr),
    .rdata_o(cur_rdata)
  );

  afs_ram #(
    .WIDTH(WORD_W),
    .DEPTH(STK_WORDS)
  ) u_stk_ram (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(cur_data),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rdata)
  );

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    row_d     = row_q;
    col_d     = col_q;
    ph_d      = ph_q;
    cnt_d     = cnt_q;
    ident_d   = ident_q;
    done_d    = 1'b0;
    rx_d      = rx_q;
    ry_d      = ry_q;
    status_d  = status_q;
    depth_d   = depth_q;
    finish    = 1'b0;
    cur_we    = 1'b0;
    cur_waddr = CUR_AW'(k_q - 1'b1);
    cur_wdata = sum;
    cur_raddr = '0;
    stk_we    = 1'b0;
    stk_waddr = base_q + SA_W'(k_q - 1'b1);
    stk_raddr = base_q;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          rx_d     = '0;
          ry_d     = '0;
          status_d = STAT_OK;
          k_d      = '0;
          row_d    = 1'b0;
          col_d    = '0;
          ph_d     = PH_A;
          case (mode_i)
            MODE_XFORM, MODE_MUL: begin
              state_d = ST_LOAD;
            end
            MODE_PUSH: begin
              if (full) begin
                status_d = STAT_OVF;
                finish   = 1'b1;
              end else begin
                state_d = ST_PUSH;
              end
            end
            MODE_POP: begin
              if (cnt_q == '0) begin
                status_d = STAT_EMPTY;
                finish   = 1'b1;
              end else begin
                state_d = ST_POP;
              end
            end
            MODE_CLEAR: begin
              cnt_d   = '0;
              ident_d = 1'b1;
              finish  = 1'b1;
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      ST_LOAD: begin
        if (int'(k_q) < ROW_WORDS) begin
          cur_raddr = row_base + CUR_AW'(k_q);
        end
        k_d = k_q + 1'b1;
        if (k_q == K_W'(ROW_WORDS)) begin
          k_d     = '0;
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        ph_d = ph_q + 1'b1;
        if (ph_q == PH_SUM) begin
          ph_d = PH_A;
          if (xform_q) begin
            if (row_q) begin
              ry_d = sum;
            end else begin
              rx_d = sum;
            end
          end else begin
            cur_we    = 1'b1;
            cur_waddr = row_base + CUR_AW'(col_q);
          end
          if (col_q == last_col) begin
            col_d = '0;
            if (!row_q) begin
              row_d   = 1'b1;
              k_d     = '0;
              state_d = ST_LOAD;
            end else begin
              finish = 1'b1;
              if (!xform_q) begin
                ident_d = 1'b0;
              end
            end
          end else begin
            col_d = col_q + 1'b1;
          end
        end
      end
      ST_PUSH: begin
        if (int'(k_q) < MAT_WORDS) begin
          cur_raddr = CUR_AW'(k_q);
        end
        stk_we = (k_q != '0);
        k_d    = k_q + 1'b1;
        if (k_q == K_W'(MAT_WORDS)) begin
          cnt_d  = cnt_q + 1'b1;
          finish = 1'b1;
        end
      end
      ST_POP: begin
        if (int'(k_q) < MAT_WORDS) begin
          stk_raddr = base_q + SA_W'(k_q);
        end
        cur_we    = (k_q != '0);
        cur_wdata = stk_rdata;
        k_d       = k_q + 1'b1;
        if (k_q == K_W'(MAT_WORDS)) begin
          cnt_d   = cnt_q - 1'b1;
          ident_d = 1'b0;
          finish  = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (finish) begin
      state_d = ST_IDLE;
      done_d  = 1'b1;
      depth_d = DEPTH_W'(cnt_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      k_q           <= '0;
      row_q         <= 1'b0;
      col_q         <= '0;
      ph_q          <= PH_A;
      cnt_q         <= '0;
      ident_q       <= 1'b1;
      stack_limit_q <= LIMIT_RESET;
      done_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      row_q   <= row_d;
      col_q   <= col_d;
      ph_q    <= ph_d;
      cnt_q   <= cnt_d;
      ident_q <= ident_d;
      done_q  <= done_d;
      if (stack_limit_we_i) begin
        stack_limit_q <= stack_limit_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      xform_q  <= (mode_i == MODE_XFORM);
      opu_q[0] <= coef_a0_i;
      opu_q[1] <= coef_a1_i;
      opu_q[2] <= coef_a2_i;
      opv_q[0] <= coef_b0_i;
      opv_q[1] <= coef_b1_i;
      opv_q[2] <= coef_b2_i;
      px_q     <= point_x_i;
      py_q     <= point_y_i;
      base_q   <= base_d;
    end
    if ((state_q == ST_LOAD) && (k_q != '0)) begin
      c_q[2'(k_q - 1'b1)] <= cur_data;
    end
    if ((state_q == ST_CALC) && (ph_q == PH_B)) begin
      acc_q <= prod;
    end
    cur_rd_idx_q <= cur_raddr;
    rx_q         <= rx_d;
    ry_q         <= ry_d;
    status_q     <= status_d;
    depth_q      <= depth_d;
  end

  assign done_o      = done_q;
  assign result_x_o  = rx_q;
  assign result_y_o  = ry_q;
  assign status_o    = status_q;
  assign depth_now_o = depth_q;

  `AFS_ASSERT_IMPL(a_idle_no_mem_write, state_q == ST_IDLE, !cur_we && !stk_we, "memory write while idle")
  `AFS_ASSERT_IMPL(a_done_not_busy, done_q, !busy_o, "result word while busy")
  `AFS_ASSERT_NEXT(a_push_full_ovf, accept && (mode_i == MODE_PUSH) && full, done_q && (status_q == STAT_OVF), "full push did not report overflow")
  `AFS_ASSERT_IMPL(a_empty_pop_zero, done_q && (status_q == STAT_EMPTY), (cnt_q == '0) && (depth_q == '0), "empty pop with saved words")
endmodule
